// File: rtl/lzssfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssfb_pkg
// Shared types and constants for the LZSS flag-byte decompressor.
// ----------------------------------------------------------------------------
package lzssfb_pkg;

	// Width of the stored length-bit count taken from the header byte
	localparam int LEN_BITS_W = 3;

	// Tokens described by one control byte
	localparam logic [3:0] FLAGS_PER_CONTROL = 4'd8;

	typedef enum logic [2:0] {
		ST_HEADER,
		ST_TOKEN,
		ST_MATCH_LO,
		ST_COPY_RD,
		ST_COPY_WR
	} state_t;

endpackage

// File: rtl/lzss_flag_byte_decompressor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_flag_byte_decompressor_core
// Decodes a flag-byte LZSS stream one compressed byte per transaction.
// A literal appears on the output register in the cycle after it is accepted.
// Header, control and literal bytes are taken one per transaction; a match
// takes its two word bytes, then each copied byte is a history RAM read
// (ST_COPY_RD), then write-back and emit (ST_COPY_WR); no input is taken.
// Reset: async, active low; waits for a header, output_length resets to 1.
// ----------------------------------------------------------------------------
module lzss_flag_byte_decompressor_core
	import lzssfb_pkg::*;
#(
	parameter int HISTORY_DEPTH   = 4096,
	parameter int MAX_LENGTH_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic        error
);

	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int LW = MAX_LENGTH_BITS + 1;

	logic [7:0] mem [HISTORY_DEPTH];

	state_t                  state_q, state_d;
	logic [15:0]             output_length_q;
	logic [LEN_BITS_W-1:0]   length_bits_q;
	logic [7:0]              flag_byte_q;
	logic [3:0]              flag_pos_q;
	logic [7:0]              match_high_q;
	logic [15:0]             bytes_left_q;
	logic [15:0]             bytes_written_q;
	logic [AW-1:0]           wr_ptr_q;
	logic [AW-1:0]           src_q;
	logic [LW-1:0]           copy_left_q;
	logic [7:0]              rd_data_s1;
	logic                    out_valid_q;
	logic [7:0]              out_byte_q;
	logic                    out_last_q;
	logic                    out_err_q;

	logic                    can_emit;
	logic                    in_acc;
	logic                    hdr_bad;
	logic                    flag_bit;
	logic [15:0]             word;
	logic [15:0]             shifted;
	logic [16:0]             match_dist;
	logic                    dist_bad;
	logic [MAX_LENGTH_BITS-1:0] low_mask;
	logic [LW-1:0]           len_raw;
	logic [LW-1:0]           len_clip;
	logic [17:0]             src_diff;
	logic [17:0]             src_wrap;
	logic [AW-1:0]           src_start;
	logic                    emit;
	logic                    res_valid;
	logic [7:0]              res_byte;
	logic                    res_last;
	logic                    res_err;
	logic                    mem_re;

	assign can_emit = !out_valid_q || out_ready;
	assign in_ready = can_emit &&
		(state_q == ST_HEADER || state_q == ST_TOKEN || state_q == ST_MATCH_LO);
	assign in_acc   = in_valid && in_ready;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = out_last_q;
	assign error     = out_err_q;

	assign hdr_bad  = in_byte > 8'(MAX_LENGTH_BITS);
	assign flag_bit = flag_byte_q[3'(flag_pos_q - 4'd1)];

	// Match word decode
	assign word       = {match_high_q, in_byte};
	assign shifted    = word >> length_bits_q;
	assign match_dist = {1'b0, shifted} + 17'd1;
	assign dist_bad   = (match_dist > {1'b0, bytes_written_q}) ||
		(match_dist > 17'(HISTORY_DEPTH));
	assign low_mask = ~({MAX_LENGTH_BITS{1'b1}} << length_bits_q);
	assign len_raw  = {1'b0, word[MAX_LENGTH_BITS-1:0] & low_mask} + LW'(1);
	assign len_clip = (16'(len_raw) > bytes_left_q) ? LW'(bytes_left_q) : len_raw;

	// Source start = (write pointer - distance) modulo history depth
	assign src_diff  = 18'(wr_ptr_q) - 18'(match_dist);
	assign src_wrap  = src_diff[17] ? (src_diff + 18'(HISTORY_DEPTH)) : src_diff;
	assign src_start = AW'(src_wrap);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_HEADER: begin
				if (in_acc && !hdr_bad && output_length_q != 16'd0)
					state_d = ST_TOKEN;
			end
			ST_TOKEN: begin
				if (in_acc && flag_pos_q != 4'd0) begin
					if (flag_bit)
						state_d = ST_MATCH_LO;
					else if (bytes_left_q == 16'd1)
						state_d = ST_HEADER;
				end
			end
			ST_MATCH_LO: begin
				if (in_acc)
					state_d = dist_bad ? ST_HEADER : ST_COPY_RD;
			end
			ST_COPY_RD: begin
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				if (can_emit) begin
					priority if (bytes_left_q == 16'd1)
						state_d = ST_HEADER;
					else if (copy_left_q == LW'(1))
						state_d = ST_TOKEN;
					else
						state_d = ST_COPY_RD;
				end
			end
			default: state_d = ST_HEADER;
		endcase
	end

	// Result and memory controls
	always_comb begin
		res_valid = 1'b0;
		res_byte  = 8'd0;
		res_err   = 1'b0;
		emit      = 1'b0;
		mem_re    = 1'b0;
		unique case (state_q)
			ST_HEADER: begin
				if (in_acc && hdr_bad) begin
					res_valid = 1'b1;
					res_err   = 1'b1;
				end
			end
			ST_TOKEN: begin
				if (in_acc && flag_pos_q != 4'd0 && !flag_bit) begin
					emit     = 1'b1;
					res_byte = in_byte;
				end
			end
			ST_MATCH_LO: begin
				if (in_acc && dist_bad) begin
					res_valid = 1'b1;
					res_err   = 1'b1;
				end
			end
			ST_COPY_RD: begin
				mem_re = 1'b1;
			end
			ST_COPY_WR: begin
				if (can_emit) begin
					emit     = 1'b1;
					res_byte = rd_data_s1;
				end
			end
			default: ;
		endcase
		if (emit)
			res_valid = 1'b1;
		res_last = emit && (bytes_left_q == 16'd1);
	end

	// History RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (emit)
			mem[wr_ptr_q] <= res_byte;
		if (mem_re)
			rd_data_s1 <= mem[src_q];
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (can_emit && res_valid) begin
			out_byte_q <= res_byte;
			out_last_q <= res_last;
			out_err_q  <= res_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_HEADER;
			output_length_q <= 16'd1;
			length_bits_q   <= '0;
			flag_byte_q     <= 8'd0;
			flag_pos_q      <= 4'd0;
			match_high_q    <= 8'd0;
			bytes_left_q    <= 16'd0;
			bytes_written_q <= 16'd0;
			wr_ptr_q        <= '0;
			src_q           <= '0;
			copy_left_q     <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				output_length_q <= cfg_wr_data;
			if (can_emit)
				out_valid_q <= res_valid;

			if (state_q == ST_HEADER && in_acc && !hdr_bad) begin
				length_bits_q   <= in_byte[LEN_BITS_W-1:0];
				flag_byte_q     <= 8'd0;
				flag_pos_q      <= 4'd0;
				match_high_q    <= 8'd0;
				bytes_written_q <= 16'd0;
				wr_ptr_q        <= '0;
				bytes_left_q    <= output_length_q;
			end

			if (state_q == ST_TOKEN && in_acc) begin
				if (flag_pos_q == 4'd0) begin
					flag_byte_q <= in_byte;
					flag_pos_q  <= FLAGS_PER_CONTROL;
				end else begin
					flag_pos_q <= flag_pos_q - 4'd1;
					if (flag_bit)
						match_high_q <= in_byte;
				end
			end

			if (state_q == ST_MATCH_LO && in_acc) begin
				src_q       <= src_start;
				copy_left_q <= len_clip;
			end

			if (state_q == ST_COPY_WR && can_emit) begin
				src_q       <= (src_q == AW'(HISTORY_DEPTH - 1)) ? '0 : src_q + AW'(1);
				copy_left_q <= copy_left_q - LW'(1);
			end

			if (emit) begin
				wr_ptr_q        <= (wr_ptr_q == AW'(HISTORY_DEPTH - 1)) ? '0
				                   : wr_ptr_q + AW'(1);
				bytes_written_q <= bytes_written_q + 16'd1;
				bytes_left_q    <= bytes_left_q - 16'd1;
			end
		end
	end

endmodule
